// File: hw/rtl/tsc_pkg.sv
// Shared types and constants for the touch swipe and tap classifier.
package tsc_pkg;

    // Coordinate and threshold widths
    localparam int COORD_BITS   = 12;
    localparam int THRESH_BITS  = 12;
    localparam int CMP_BITS     = (COORD_BITS > THRESH_BITS) ? COORD_BITS : THRESH_BITS;
    localparam int GESTURE_BITS = 3;
    localparam int PHASE_BITS   = 2;

    localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(30);

    // Touch phase codes
    typedef enum logic [PHASE_BITS-1:0] {
        PH_IDLE     = 2'd0,
        PH_PRESSED  = 2'd1,
        PH_HELD     = 2'd2,
        PH_RELEASED = 2'd3
    } t_phase;

    // Gesture codes
    typedef enum logic [GESTURE_BITS-1:0] {
        G_NONE  = 3'd0,
        G_LEFT  = 3'd1,
        G_RIGHT = 3'd2,
        G_UP    = 3'd3,
        G_DOWN  = 3'd4,
        G_TAP   = 3'd5
    } t_gesture;

    // One touch sample
    typedef struct packed {
        logic                  present;
        t_phase                phase;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } t_sample;

    // One classification result
    typedef struct packed {
        t_gesture              gesture;
        logic [COORD_BITS-1:0] tap_x;
        logic [COORD_BITS-1:0] tap_y;
    } t_result;

    // Absolute value of a signed delta one bit wider than a coordinate
    function automatic logic [COORD_BITS-1:0] abs_delta(input logic [COORD_BITS:0] d);
        logic [COORD_BITS:0] neg;
        neg = ~d + (COORD_BITS+1)'(1);
        return d[COORD_BITS] ? neg[COORD_BITS-1:0] : d[COORD_BITS-1:0];
    endfunction

endpackage

// File: hw/rtl/tsc_classify.sv
// Tracking state and gesture decision for one touch sample.
module tsc_classify (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_fire,
    input  tsc_pkg::t_sample                  i_sample,
    input  logic [tsc_pkg::THRESH_BITS-1:0]   i_threshold,
    output tsc_pkg::t_result                  o_result,
    output logic                              o_tracking
);

    logic [tsc_pkg::COORD_BITS-1:0] r_start_x, n_start_x;
    logic [tsc_pkg::COORD_BITS-1:0] r_start_y, n_start_y;
    logic                           r_tracking, n_tracking;

    logic [tsc_pkg::COORD_BITS:0]   dx, dy;
    logic [tsc_pkg::CMP_BITS-1:0]   ax, ay, thr;
    logic                           swipe_x, swipe_y, moving;

    // Signed deltas from the start point and their magnitudes
    always_comb begin
        dx  = {1'b0, i_sample.x} - {1'b0, r_start_x};
        dy  = {1'b0, i_sample.y} - {1'b0, r_start_y};
        ax  = tsc_pkg::CMP_BITS'(tsc_pkg::abs_delta(dx));
        ay  = tsc_pkg::CMP_BITS'(tsc_pkg::abs_delta(dy));
        thr = tsc_pkg::CMP_BITS'(i_threshold);
        swipe_x = (ax > thr) && (ax > ay);
        swipe_y = (ay > thr) && (ay > ax);
        moving  = i_sample.present && r_tracking &&
                  ((i_sample.phase == tsc_pkg::PH_HELD) ||
                   (i_sample.phase == tsc_pkg::PH_RELEASED));
    end

    // Decision and next state
    always_comb begin
        n_start_x        = r_start_x;
        n_start_y        = r_start_y;
        n_tracking       = r_tracking;
        o_result.gesture = tsc_pkg::G_NONE;
        o_result.tap_x   = '0;
        o_result.tap_y   = '0;
        if (i_sample.present && (i_sample.phase == tsc_pkg::PH_PRESSED)) begin
            n_start_x  = i_sample.x;
            n_start_y  = i_sample.y;
            n_tracking = 1'b1;
        end else if (moving) begin
            if (swipe_x) begin
                o_result.gesture = dx[tsc_pkg::COORD_BITS] ? tsc_pkg::G_LEFT : tsc_pkg::G_RIGHT;
                n_tracking       = 1'b0;
            end else if (swipe_y) begin
                o_result.gesture = dy[tsc_pkg::COORD_BITS] ? tsc_pkg::G_UP : tsc_pkg::G_DOWN;
                n_tracking       = 1'b0;
            end else if (i_sample.phase == tsc_pkg::PH_RELEASED) begin
                o_result.gesture = tsc_pkg::G_TAP;
                o_result.tap_x   = r_start_x;
                o_result.tap_y   = r_start_y;
                n_tracking       = 1'b0;
            end
        end
    end

    // State registers, updated as a sample leaves the input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tracking <= 1'b0;
            r_start_x  <= '0;
            r_start_y  <= '0;
        end else if (i_fire) begin
            r_tracking <= n_tracking;
            r_start_x  <= n_start_x;
            r_start_y  <= n_start_y;
        end
    end

    assign o_tracking = r_tracking;

endmodule

// File: hw/rtl/touch_swipe_tap_classifier.sv
// Top level of the touch swipe and tap classifier.
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one touch sample per
//   transaction: presence, phase (idle, pressed, held, released), x and y.
//   Output channel (o_out_valid / i_out_ready) gives exactly one result per
//   sample: gesture code and, for a tap, the start point (zero otherwise).
//   Config channel (i_cfg_valid / o_cfg_ready, always ready) writes the 12-bit
//   swipe threshold; only the user ensures it is written while the block is idle.
// Timing:
//   Two register stages: the sample register, then the result register;
//   a sample's result is registered in the result register. One sample per
//   cycle is sustained while the output is not stalled. The path between
//   the stages is one subtract, absolute value and compare per axis.
// Reset:
//   Both stages empty, tracking cleared, start point zero, threshold 30.
// Stall:
//   A held result stays stable; the sample register still fills, and input
//   ready drops only once both stages are occupied and the output is stalled.
module touch_swipe_tap_classifier (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // sample input
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_touch_present,
    input  logic [tsc_pkg::PHASE_BITS-1:0]    i_touch_phase,
    input  logic [tsc_pkg::COORD_BITS-1:0]    i_touch_x,
    input  logic [tsc_pkg::COORD_BITS-1:0]    i_touch_y,
    // result output
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [tsc_pkg::GESTURE_BITS-1:0]  o_gesture,
    output logic [tsc_pkg::COORD_BITS-1:0]    o_tap_x,
    output logic [tsc_pkg::COORD_BITS-1:0]    o_tap_y,
    // threshold write
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tsc_pkg::THRESH_BITS-1:0]   i_cfg_data
);

    logic                             r_s1_vld;
    tsc_pkg::t_sample                 r_sample;
    logic                             r_out_vld;
    tsc_pkg::t_result                 r_result;
    logic [tsc_pkg::THRESH_BITS-1:0]  r_threshold;

    tsc_pkg::t_result                 cls_result;
    logic                             cls_tracking;
    logic                             out_free, s1_fire, in_fire;

    // Handshake control
    assign out_free    = !r_out_vld || i_out_ready;
    assign s1_fire     = r_s1_vld && out_free;
    assign o_in_ready  = !r_s1_vld || out_free;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // Threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= tsc_pkg::THRESH_RESET;
        end else if (i_cfg_valid) begin
            r_threshold <= i_cfg_data;
        end
    end

    // Sample stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_sample.present <= i_touch_present;
            r_sample.phase   <= tsc_pkg::t_phase'(i_touch_phase);
            r_sample.x       <= i_touch_x;
            r_sample.y       <= i_touch_y;
        end
    end

    // Classification against the tracking state
    tsc_classify u_classify (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (s1_fire),
        .i_sample    (r_sample),
        .i_threshold (r_threshold),
        .o_result    (cls_result),
        .o_tracking  (cls_tracking)
    );

    // Result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_result <= cls_result;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_gesture   = r_result.gesture;
    assign o_tap_x     = r_result.tap_x;
    assign o_tap_y     = r_result.tap_y;

`ifndef SYNTHESIS
    // Tap coordinates are zero unless the result is a tap
    a_tap_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_result.gesture != tsc_pkg::G_TAP)) |->
            ((r_result.tap_x == '0) && (r_result.tap_y == '0)))
        else $error("tap coordinates set on a non-tap result");

    // Any reported gesture ends tracking
    a_gesture_ends_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && (cls_result.gesture != tsc_pkg::G_NONE)) |=> !cls_tracking)
        else $error("tracking still set after a gesture");

    // Both stages full with a stalled output blocks the input
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && r_out_vld && !i_out_ready) |-> !o_in_ready)
        else $error("input ready while pipeline full and stalled");

    // A result is only loaded from a valid sample
    a_load_from_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_free && !r_s1_vld) |=> !r_out_vld)
        else $error("result valid without a sample");
`endif

endmodule
